// File: rtl/uart_dma_ring_buffer_manager_top_assert.svh
// Assertion macros shared by the ring buffer manager RTL.
`ifndef UART_DMA_RING_BUFFER_MANAGER_TOP_ASSERT_SVH
`define UART_DMA_RING_BUFFER_MANAGER_TOP_ASSERT_SVH

// Check that cond holds at every clock edge outside reset.
`define UDRB_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that ante implies cons at the same clock edge.
`define UDRB_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/udrb_pkg.sv
package udrb_pkg;

    localparam int DEPTH = 256;
    localparam int PTR_W = $clog2(DEPTH);

    typedef logic [PTR_W-1:0] ptr_t;

    typedef enum logic [2:0] {
        MODE_PUT     = 3'd0,
        MODE_SERVICE = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_GET     = 3'd3,
        MODE_COUNT   = 3'd4
    } mode_t;

    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] tx_data;
        logic [7:0] line_data;
        logic       transmitter_empty;
    } udrb_in_t;

    typedef struct packed {
        logic       send_valid;
        logic [7:0] send_byte;
        logic       accepted;
        logic       read_valid;
        logic [7:0] read_byte;
        logic [7:0] pending_count;
        logic       irq_enabled;
    } udrb_out_t;

    function automatic ptr_t ring_next(ptr_t p);
        ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

    function automatic ptr_t ring_dist(ptr_t from, ptr_t to);
        ring_dist = (to >= from) ? ptr_t'(to - from) : ptr_t'(PTR_W'(DEPTH) - (from - to));
    endfunction

endpackage

// File: rtl/uart_dma_ring_buffer_manager_top.sv
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_data  (udrb_in_t)
// out     | output    | out_valid/out_ready| out_data (udrb_out_t)
// One request accepted per cycle while in_ready is high; its result appears in the cycle after acceptance.
// The result is registered, as is the read port of the transmit and receive rings.
// in_ready drops only while a result waits and out_ready is low.
// rst_n clears all pointers and the interrupt flag at once; ring contents are not cleared.
module uart_dma_ring_buffer_manager_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  udrb_pkg::udrb_in_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output udrb_pkg::udrb_out_t out_data
);
    import udrb_pkg::*;

    logic [7:0] tx_mem [DEPTH];
    logic [7:0] rx_mem [DEPTH];

    ptr_t tx_head_reg, tx_head_next;
    ptr_t tx_tail_reg, tx_tail_next;
    ptr_t rx_head_reg, rx_head_next;
    ptr_t rx_tail_reg, rx_tail_next;
    ptr_t dma_ptr_reg, dma_ptr_next;
    logic irq_reg, irq_next;

    logic       out_valid_reg;
    logic       send_valid_reg, send_valid_next;
    logic       accepted_reg, accepted_next;
    logic       read_valid_reg, read_valid_next;
    logic [7:0] pend_reg, pend_next;
    logic [7:0] tx_rd_reg;
    logic [7:0] rx_rd_reg;

    logic       in_fire;
    logic       tx_write;
    logic       rx_write;
    ptr_t       arrived;
    ptr_t       room;
    ptr_t       pend_full;
    logic [PTR_W+7:0] pend_ext;

    assign in_ready = !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        tx_head_next    = tx_head_reg;
        tx_tail_next    = tx_tail_reg;
        rx_head_next    = rx_head_reg;
        rx_tail_next    = rx_tail_reg;
        dma_ptr_next    = dma_ptr_reg;
        irq_next        = irq_reg;
        send_valid_next = 1'b0;
        accepted_next   = 1'b0;
        read_valid_next = 1'b0;
        tx_write        = 1'b0;
        rx_write        = 1'b0;
        arrived         = ring_dist(rx_head_reg, dma_ptr_reg);
        room            = ptr_t'(PTR_W'(DEPTH - 1) - ring_dist(rx_tail_reg, rx_head_reg));
        unique case (in_data.mode)
            MODE_PUT:
            begin
                if (ring_dist(tx_tail_reg, tx_head_reg) < PTR_W'(DEPTH - 1))
                begin
                    tx_write      = 1'b1;
                    tx_head_next  = ring_next(tx_head_reg);
                    irq_next      = 1'b1;
                    accepted_next = 1'b1;
                end
            end
            MODE_SERVICE:
            begin
                if (in_data.transmitter_empty && irq_reg)
                begin
                    if (tx_head_reg == tx_tail_reg)
                    begin
                        irq_next = 1'b0;
                    end
                    else
                    begin
                        send_valid_next = 1'b1;
                        tx_tail_next    = ring_next(tx_tail_reg);
                    end
                end
                if (arrived != '0)
                begin
                    rx_head_next = dma_ptr_reg;
                    if (room < arrived)
                    begin
                        rx_tail_next = ring_next(dma_ptr_reg);
                    end
                end
            end
            MODE_LINE:
            begin
                rx_write     = 1'b1;
                dma_ptr_next = ring_next(dma_ptr_reg);
            end
            MODE_GET:
            begin
                if (rx_head_reg != rx_tail_reg)
                begin
                    read_valid_next = 1'b1;
                    rx_tail_next    = ring_next(rx_tail_reg);
                end
            end
            default:
            begin
            end
        endcase
        pend_full = ring_dist(rx_tail_next, rx_head_next);
        pend_ext  = (PTR_W + 8)'(pend_full);
        pend_next = (pend_ext > (PTR_W + 8)'(255)) ? 8'hFF : 8'(pend_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_head_reg   <= '0;
            tx_tail_reg   <= '0;
            rx_head_reg   <= '0;
            rx_tail_reg   <= '0;
            dma_ptr_reg   <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                tx_head_reg <= tx_head_next;
                tx_tail_reg <= tx_tail_next;
                rx_head_reg <= rx_head_next;
                rx_tail_reg <= rx_tail_next;
                dma_ptr_reg <= dma_ptr_next;
                irq_reg     <= irq_next;
            end
            if (in_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            send_valid_reg <= send_valid_next;
            accepted_reg   <= accepted_next;
            read_valid_reg <= read_valid_next;
            pend_reg       <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && tx_write)
        begin
            tx_mem[tx_head_reg] <= in_data.tx_data;
        end
        if (in_fire)
        begin
            tx_rd_reg <= tx_mem[tx_tail_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && rx_write)
        begin
            rx_mem[dma_ptr_reg] <= in_data.line_data;
        end
        if (in_fire)
        begin
            rx_rd_reg <= rx_mem[rx_tail_reg];
        end
    end

    assign out_valid              = out_valid_reg;
    assign out_data.send_valid    = send_valid_reg;
    assign out_data.send_byte     = send_valid_reg ? tx_rd_reg : 8'h00;
    assign out_data.accepted      = accepted_reg;
    assign out_data.read_valid    = read_valid_reg;
    assign out_data.read_byte     = read_valid_reg ? rx_rd_reg : 8'h00;
    assign out_data.pending_count = pend_reg;
    assign out_data.irq_enabled   = irq_reg;

`include "uart_dma_ring_buffer_manager_top_assert.svh"

    `UDRB_ASSERT_IMPLY(a_one_event, out_valid_reg, $onehot0({send_valid_reg, accepted_reg, read_valid_reg}), "more than one event flag in a result")
    `UDRB_ASSERT_IMPLY(a_put_sets_irq, out_valid_reg && accepted_reg, irq_reg, "stored put left the interrupt flag clear")
    `UDRB_ASSERT_IMPLY(a_send_keeps_irq, out_valid_reg && send_valid_reg, irq_reg, "byte sent with the interrupt flag clear")
    `UDRB_ASSERT_ALWAYS(a_ptr_range, (tx_head_reg < PTR_W'(DEPTH - 1)) || (tx_head_reg == PTR_W'(DEPTH - 1)), "transmit head beyond ring")

endmodule

// File: tb/uart_dma_ring_buffer_manager_top_tb.sv
`timescale 1ns / 100ps

module uart_dma_ring_buffer_manager_top_tb;

    import udrb_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_REPORTS = 10;
    localparam int DRAIN_CYCLES = 5;
    localparam int LONG_HOLD_CYCLES = 300;

    localparam logic [2:0] MODE_SPARE_5 = 3'd5;
    localparam logic [2:0] MODE_SPARE_6 = 3'd6;
    localparam logic [2:0] MODE_SPARE_7 = 3'd7;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    udrb_in_t  in_data;
    logic      out_valid;
    logic      out_ready;
    udrb_out_t out_data;

    uart_dma_ring_buffer_manager_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    // Predicted port state
    ptr_t       txq_wr;
    ptr_t       txq_rd;
    logic       tx_irq_en;
    ptr_t       dma_wr_ptr;
    ptr_t       rx_sync_ptr;
    ptr_t       rx_rd_ptr;
    logic [7:0] tx_bytes [DEPTH];
    logic [7:0] rx_bytes [DEPTH];

    udrb_out_t expected_results [$];

    int mismatch_count;
    int cycle_count;
    int long_hold;
    bit src_idle_on;
    bit sink_stall_on;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic udrb_in_t make_req(logic [2:0] mode, logic [7:0] tx_byte,
                                          logic [7:0] line_byte, logic txe);
        make_req = '{mode, tx_byte, line_byte, txe};
    endfunction

    function automatic udrb_out_t ring_manager_result(udrb_in_t req);
        udrb_out_t res;
        ptr_t      tx_fill;
        ptr_t      arrived;
        ptr_t      room;
        res = '0;
        case (req.mode)
            MODE_PUT:
            begin
                tx_fill = txq_wr - txq_rd;
                if (tx_fill != ptr_t'(DEPTH - 1))
                begin
                    tx_bytes[txq_wr] = req.tx_data;
                    txq_wr++;
                    tx_irq_en = 1'b1;
                    res.accepted = 1'b1;
                end
            end
            MODE_SERVICE:
            begin
                if (req.transmitter_empty && tx_irq_en)
                begin
                    if (txq_wr == txq_rd)
                        tx_irq_en = 1'b0;
                    else
                    begin
                        res.send_valid = 1'b1;
                        res.send_byte = tx_bytes[txq_rd];
                        txq_rd++;
                    end
                end
                arrived = dma_wr_ptr - rx_sync_ptr;
                if (arrived != 0)
                begin
                    room = ptr_t'(DEPTH - 1) - ptr_t'(rx_sync_ptr - rx_rd_ptr);
                    rx_sync_ptr = dma_wr_ptr;
                    // drop the oldest bytes on overflow
                    if (room < arrived)
                        rx_rd_ptr = rx_sync_ptr + 1'b1;
                end
            end
            MODE_LINE:
            begin
                rx_bytes[dma_wr_ptr] = req.line_data;
                dma_wr_ptr++;
            end
            MODE_GET:
            begin
                if (rx_sync_ptr != rx_rd_ptr)
                begin
                    res.read_valid = 1'b1;
                    res.read_byte = rx_bytes[rx_rd_ptr];
                    rx_rd_ptr++;
                end
            end
            default:
            begin
            end
        endcase
        res.pending_count = rx_sync_ptr - rx_rd_ptr;
        res.irq_enabled = tx_irq_en;
        return res;
    endfunction

    task automatic send_request(udrb_in_t req);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        do
            @(posedge clk);
        while (!in_ready);
        expected_results.push_back(ring_manager_result(req));
    endtask

    task automatic test_basic_ops();
        send_request(make_req(MODE_COUNT, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_GET, 8'hFF, 8'hFF, 1'b1));
        send_request(make_req(MODE_SERVICE, 8'h00, 8'h00, 1'b1));
        send_request(make_req(MODE_PUT, 8'h00, 8'hFF, 1'b0));
        send_request(make_req(MODE_PUT, 8'hFF, 8'h00, 1'b1));
        send_request(make_req(MODE_SERVICE, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_SERVICE, 8'h00, 8'h00, 1'b1));
        send_request(make_req(MODE_SERVICE, 8'h00, 8'h00, 1'b1));
        send_request(make_req(MODE_SERVICE, 8'h00, 8'h00, 1'b1));
        send_request(make_req(MODE_SERVICE, 8'h00, 8'h00, 1'b1));
        send_request(make_req(MODE_LINE, 8'hFF, 8'h00, 1'b0));
        send_request(make_req(MODE_LINE, 8'h00, 8'hFF, 1'b0));
        send_request(make_req(MODE_LINE, 8'h5A, 8'hA5, 1'b1));
        send_request(make_req(MODE_COUNT, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_GET, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_SERVICE, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_GET, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_GET, 8'h00, 8'h00, 1'b1));
        send_request(make_req(MODE_COUNT, 8'hFF, 8'hFF, 1'b1));
        send_request(make_req(MODE_SPARE_5, 8'hFF, 8'hFF, 1'b1));
        send_request(make_req(MODE_SPARE_6, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_SPARE_7, 8'hFF, 8'h00, 1'b1));
        send_request(make_req(MODE_GET, 8'h00, 8'h00, 1'b0));
        send_request(make_req(MODE_GET, 8'h00, 8'h00, 1'b1));
    endtask

    task automatic test_tx_ring_full();
        // hold the receiver off while puts keep coming
        long_hold = LONG_HOLD_CYCLES;
        src_idle_on = 1'b0;
        for (int i = 0; i < DEPTH + 1; i++)
            send_request(make_req(MODE_PUT, 8'($urandom), 8'($urandom), 1'($urandom)));
        src_idle_on = 1'b1;
    endtask

    task automatic test_rx_overflow_and_lap();
        int   first_batch;
        int   second_batch;
        ptr_t room;
        first_batch = $urandom_range(200, 240);
        for (int i = 0; i < first_batch; i++)
            send_request(make_req(MODE_LINE, 8'($urandom), 8'($urandom), 1'($urandom)));
        send_request(make_req(MODE_SERVICE, 8'($urandom), 8'($urandom), 1'($urandom)));
        // lap the sync point once and overrun the free space
        room = ptr_t'(DEPTH - 1) - ptr_t'(rx_sync_ptr - rx_rd_ptr);
        second_batch = DEPTH + room + $urandom_range(1, 20);
        for (int i = 0; i < second_batch; i++)
            send_request(make_req(MODE_LINE, 8'($urandom), 8'($urandom), 1'($urandom)));
        send_request(make_req(MODE_SERVICE, 8'($urandom), 8'($urandom), 1'($urandom)));
        for (int i = 0; i < 5; i++)
            send_request(make_req(MODE_GET, 8'($urandom), 8'($urandom), 1'($urandom)));
        send_request(make_req(MODE_COUNT, 8'($urandom), 8'($urandom), 1'($urandom)));
    endtask

    task automatic test_random_traffic(int n);
        int         r;
        logic [2:0] mode;
        for (int i = 0; i < n; i++)
        begin
            if (i % 40 == 0)
            begin
                src_idle_on = ($urandom_range(0, 3) != 0);
                sink_stall_on = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 25)
                mode = MODE_PUT;
            else if (r < 55)
                mode = MODE_SERVICE;
            else if (r < 75)
                mode = MODE_LINE;
            else if (r < 95)
                mode = MODE_GET;
            else if (r < 98)
                mode = MODE_COUNT;
            else
                mode = 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
            send_request(make_req(mode, 8'($urandom), 8'($urandom),
                                  ($urandom_range(0, 3) != 0)));
        end
        src_idle_on = 1'b1;
        sink_stall_on = 1'b1;
    endtask

    // Result sink with random stalls and one long hold-off
    initial
    begin
        int stall_left;
        out_ready <= 1'b0;
        stall_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                out_ready <= 1'b0;
                long_hold--;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (sink_stall_on && $urandom_range(0, 7) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        udrb_out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected result %p", $realtime, out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_data.send_valid !== want.send_valid ||
                    out_data.send_byte !== want.send_byte ||
                    out_data.accepted !== want.accepted ||
                    out_data.read_valid !== want.read_valid ||
                    out_data.read_byte !== want.read_byte ||
                    out_data.pending_count !== want.pending_count ||
                    out_data.irq_enabled !== want.irq_enabled)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("%0t: mismatch expected %p actual %p",
                                 $realtime, want, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        txq_wr = '0;
        txq_rd = '0;
        tx_irq_en = 1'b0;
        dma_wr_ptr = '0;
        rx_sync_ptr = '0;
        rx_rd_ptr = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tx_bytes[i] = '0;
            rx_bytes[i] = '0;
        end
        mismatch_count = 0;
        cycle_count = 0;
        long_hold = 0;
        src_idle_on = 1'b1;
        sink_stall_on = 1'b1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic_ops();
        test_tx_ring_full();
        test_rx_overflow_and_lap();
        test_random_traffic(140);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/udrb_pkg.sv
rtl/uart_dma_ring_buffer_manager_top.sv
tb/uart_dma_ring_buffer_manager_top_tb.sv
